// File: design/breakpoint_step_debug_unit_top_macros.svh
// assertion helpers shared by the debug unit
`ifndef BREAKPOINT_STEP_DEBUG_UNIT_TOP_MACROS_SVH
`define BREAKPOINT_STEP_DEBUG_UNIT_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BSDU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define BSDU_ASSERT_NEXT(lbl, cond, nxt, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error(msg);

`endif

// File: design/bsdu_pkg.sv
package bsdu_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int ADDR_W  = 24;
	localparam int COUNT_W = 32;

	typedef logic [2:0] cmd_t;

	localparam cmd_t CMD_RETIRE = 3'd0;
	localparam cmd_t CMD_ADD    = 3'd1;
	localparam cmd_t CMD_DELETE = 3'd2;
	localparam cmd_t CMD_STEP   = 3'd3;
	localparam cmd_t CMD_RUN    = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXISTS    = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

endpackage

// File: design/bsdu_if.sv
interface bsdu_req_if import bsdu_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [2:0]           cmd;
	logic [ADDR_W-1:0]    address;
	logic [COUNT_W-1:0]   count;

	modport source(output valid, output cmd, output address, output count, input ready);
	modport sink(input valid, input cmd, input address, input count, output ready);
endinterface

interface bsdu_rsp_if;
	logic       valid;
	logic       ready;
	logic       halt;
	logic       hit;
	logic [1:0] status;

	modport source(output valid, output halt, output hit, output status, input ready);
	modport sink(input valid, input halt, input hit, input status, output ready);
endinterface

// File: design/breakpoint_step_debug_unit_top.sv
// Breakpoint and single-step debug unit.
// req channel: one command per beat (cmd, address, count); cmd 0 checks a
// retired pc, 1 adds a breakpoint, 2 deletes one, 3 loads a step count,
// 4 starts free run. rsp channel: one beat per command with halt, hit, status.
// Breakpoint addresses live in a 16-entry synchronous RAM with a registered
// read; valid marks, slot count, free-run flag and step count are flops.
// Retire, add and delete walk the slots in use one RAM read per cycle,
// stopping early on a match or, for add, on the first freed slot. Step,
// run and unknown codes do no scan. One command is worked on at a time;
// req is ready again once the response is loaded into the output register.
// A stalled rsp holds its beat; a finished command waits in place until the
// output register frees, and the next command may be accepted meanwhile only
// after that. Reset clears valid marks, counts, free run and both channels;
// the address RAM itself is not cleared.
`include "breakpoint_step_debug_unit_top_macros.svh"

module breakpoint_step_debug_unit_top import bsdu_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	bsdu_req_if.sink      req,
	bsdu_rsp_if.source    rsp
);

	state_t state_q, state_n;

	logic [2:0]         cmd_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [COUNT_W-1:0] count_q;

	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]   used_q;
	logic               free_run_q;
	logic [COUNT_W-1:0] steps_q;

	logic [CNT_W-1:0]   idx_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [ADDR_W-1:0]  rd_data_s1;

	logic [ADDR_W-1:0]  bp_mem [ENTRIES];

	logic               rsp_vld_q;
	logic               halt_q;
	logic               hit_q;
	status_t            status_q;

	logic               accept;
	logic               is_scan;
	logic               issue_ok;
	logic               match;
	logic               free_at;
	logic               fin;
	logic               out_free;
	logic               do_fin;
	logic               issue;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic               set_vld;
	logic               clr_vld;
	logic [IDX_W-1:0]   vld_idx;
	logic [CNT_W-1:0]   used_n;
	logic               halt_n;
	logic               hit_n;
	status_t            status_n;
	logic               free_run_n;
	logic [COUNT_W-1:0] steps_n;

	assign accept   = req.valid && req.ready;
	assign is_scan  = (cmd_q == CMD_RETIRE) || (cmd_q == CMD_ADD) || (cmd_q == CMD_DELETE);
	assign issue_ok = idx_q < used_q;
	assign match    = vld_s1 && valid_q[idx_s1] && (rd_data_s1 == addr_q);
	// add stops at the first freed slot unless an earlier slot just matched
	assign free_at  = (cmd_q == CMD_ADD) && issue_ok && !valid_q[idx_q[IDX_W-1:0]];
	assign out_free = !rsp_vld_q || rsp.ready;

	// next state and handshake
	always_comb begin
		state_n   = state_q;
		req.ready = 1'b0;
		fin       = 1'b0;
		issue     = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_n = S_SCAN;
				end
			end
			S_SCAN: begin
				fin   = !is_scan || match || free_at || !issue_ok;
				issue = !fin;
				if (fin && out_free) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	assign do_fin = fin && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// outcome of the command at the end of its scan
	always_comb begin
		wr_en      = 1'b0;
		wr_idx     = idx_q[IDX_W-1:0];
		set_vld    = 1'b0;
		clr_vld    = 1'b0;
		vld_idx    = idx_s1;
		used_n     = used_q;
		halt_n     = 1'b0;
		hit_n      = 1'b0;
		status_n   = ST_OK;
		free_run_n = free_run_q;
		steps_n    = steps_q;
		case (cmd_q)
			CMD_RETIRE: begin
				hit_n = match;
				if (!(free_run_q && used_q == '0)) begin
					if (free_run_q && match) begin
						free_run_n = 1'b0;
						steps_n    = '0;
					end
					if (steps_n != '0) begin
						steps_n = steps_n - COUNT_W'(1);
						if (match) begin
							free_run_n = 1'b0;
							steps_n    = '0;
						end
					end else begin
						halt_n = !free_run_n;
					end
				end
			end
			CMD_ADD: begin
				if (match) begin
					status_n = ST_EXISTS;
				end else if (free_at) begin
					wr_en   = 1'b1;
					set_vld = 1'b1;
					vld_idx = idx_q[IDX_W-1:0];
				end else if (used_q == CNT_W'(ENTRIES)) begin
					status_n = ST_FULL;
				end else begin
					wr_en   = 1'b1;
					wr_idx  = used_q[IDX_W-1:0];
					set_vld = 1'b1;
					vld_idx = used_q[IDX_W-1:0];
					used_n  = used_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (match) begin
					clr_vld = 1'b1;
					if (CNT_W'(idx_s1) + CNT_W'(1) == used_q) begin
						used_n = used_q - CNT_W'(1);
					end
				end else begin
					status_n = ST_NOT_FOUND;
				end
			end
			CMD_STEP: begin
				steps_n = count_q;
			end
			CMD_RUN: begin
				free_run_n = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			addr_q  <= req.address;
			count_q <= req.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			used_q     <= '0;
			free_run_q <= 1'b0;
			steps_q    <= '0;
		end else if (do_fin) begin
			if (set_vld) begin
				valid_q[vld_idx] <= 1'b1;
			end
			if (clr_vld) begin
				valid_q[vld_idx] <= 1'b0;
			end
			used_q     <= used_n;
			free_run_q <= free_run_n;
			steps_q    <= steps_n;
		end
	end

	// scan pointer and read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (accept) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else if (issue) begin
			idx_q  <= idx_q + CNT_W'(1);
			vld_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1 <= idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (do_fin && wr_en) begin
			bp_mem[wr_idx] <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= bp_mem[idx_q[IDX_W-1:0]];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (do_fin) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_fin) begin
			halt_q   <= halt_n;
			hit_q    <= hit_n;
			status_q <= status_n;
		end
	end

	assign rsp.valid  = rsp_vld_q;
	assign rsp.halt   = halt_q;
	assign rsp.hit    = hit_q;
	assign rsp.status = status_q;

	`BSDU_ASSERT(a_used_range, used_q <= CNT_W'(ENTRIES), "slot count beyond table size")
	`BSDU_ASSERT(a_empty_no_valid, (used_q != '0) || (valid_q == '0),
		"valid slot with empty table")
	`BSDU_ASSERT(a_scan_bound, (state_q != S_SCAN) || (idx_q <= used_q),
		"scan pointer past slots in use")
	`BSDU_ASSERT_NEXT(a_one_at_a_time, accept, !req.ready,
		"new command taken while one is at work")

endmodule

// File: verif/breakpoint_step_debug_unit_top_test.sv
module breakpoint_step_debug_unit_top_test import bsdu_pkg::*; ();

	localparam cmd_t CMD_SPARE_FIRST = CMD_RUN + 3'd1;
	localparam cmd_t CMD_SPARE_LAST  = 3'd7;
	localparam int   STALL_LIMIT     = 3000;
	localparam int   HOLD_CYCLES     = 300;
	localparam int   POOL_SIZE       = 20;
	localparam int   SEGMENTS        = 11;
	localparam int   SEGMENT_ITEMS   = 150;

	typedef struct packed {
		logic    halt;
		logic    hit;
		status_t status;
	} debug_resp_t;

	class halt_scoreboard;
		logic [ADDR_W-1:0]  bp_addr_q [ENTRIES];
		bit                 bp_live [ENTRIES];
		int                 slots_in_use;
		bit                 free_running;
		logic [COUNT_W-1:0] steps_to_go;
		debug_resp_t        expected_q [$];
		int                 mismatches;
		int                 responses_seen;

		function new();
			foreach (bp_live[i]) begin
				bp_live[i] = 1'b0;
				bp_addr_q[i] = '0;
			end
			slots_in_use = 0;
			free_running = 1'b0;
			steps_to_go = '0;
			mismatches = 0;
			responses_seen = 0;
		endfunction

		// predict the response of one accepted command and queue it
		function void note_command(cmd_t c, logic [ADDR_W-1:0] a, logic [COUNT_W-1:0] n);
			debug_resp_t r;
			int i;
			bit matched;
			bit placed;
			r = '{halt: 1'b0, hit: 1'b0, status: ST_OK};
			case (c)
				CMD_RETIRE: begin
					matched = 1'b0;
					for (i = 0; i < slots_in_use; i++)
						if (bp_live[i] && bp_addr_q[i] == a)
							matched = 1'b1;
					r.hit = matched;
					// free run over an empty table never stops the core
					if (!(free_running && slots_in_use == 0)) begin
						if (free_running && matched) begin
							free_running = 1'b0;
							steps_to_go = '0;
						end
						if (steps_to_go != 0) begin
							steps_to_go = steps_to_go - 1;
							if (matched) begin
								free_running = 1'b0;
								steps_to_go = '0;
							end
						end else if (!free_running) begin
							r.halt = 1'b1;
						end
					end
				end
				CMD_ADD: begin
					placed = 1'b0;
					for (i = 0; i < slots_in_use && !placed; i++) begin
						if (bp_live[i]) begin
							if (bp_addr_q[i] == a) begin
								r.status = ST_EXISTS;
								placed = 1'b1;
							end
						end else begin
							// first freed slot wins, later duplicates go unseen
							bp_addr_q[i] = a;
							bp_live[i] = 1'b1;
							placed = 1'b1;
						end
					end
					if (!placed) begin
						if (slots_in_use >= ENTRIES) begin
							r.status = ST_FULL;
						end else begin
							bp_addr_q[slots_in_use] = a;
							bp_live[slots_in_use] = 1'b1;
							slots_in_use++;
						end
					end
				end
				CMD_DELETE: begin
					placed = 1'b0;
					for (i = 0; i < slots_in_use && !placed; i++) begin
						if (bp_live[i] && bp_addr_q[i] == a) begin
							bp_live[i] = 1'b0;
							if (i + 1 == slots_in_use)
								slots_in_use--;
							placed = 1'b1;
						end
					end
					if (!placed)
						r.status = ST_NOT_FOUND;
				end
				CMD_STEP: steps_to_go = n;
				CMD_RUN:  free_running = 1'b1;
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_response(logic halt, logic hit, logic [1:0] status);
			debug_resp_t e;
			responses_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d: none expected, got halt=%0b hit=%0b status=%0d",
						responses_seen, halt, hit, status);
				return;
			end
			e = expected_q.pop_front();
			if (halt !== e.halt || hit !== e.hit || status !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("response %0d: expected halt=%0b hit=%0b status=%0d, got halt=%0b hit=%0b status=%0d",
						responses_seen, e.halt, e.hit, e.status, halt, hit, status);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bsdu_req_if req_ch ();
	bsdu_rsp_if rsp_ch ();

	breakpoint_step_debug_unit_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	halt_scoreboard    sb;
	int                sent_count = 0;
	int                stall_cycles = 0;
	bit                calm = 1'b0;
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

	// command mix per segment profile: add heavy, retire heavy, delete heavy
	int prof_ret  [3] = '{30, 60, 25};
	int prof_add  [3] = '{45, 10, 20};
	int prof_del  [3] = '{10, 8, 40};
	int prof_step [3] = '{7, 12, 7};
	int prof_run  [3] = '{5, 8, 6};

	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_cmd(cmd_t c, logic [ADDR_W-1:0] a, logic [COUNT_W-1:0] n);
		int gap;
		bit taken;
		gap = calm ? 0 : pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.cmd = c;
		req_ch.address = a;
		req_ch.count = n;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			if (req_ch.ready) begin
				taken = 1'b1;
				sb.note_command(c, a, n);
				sent_count++;
			end
			@(negedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_response(rsp_ch.halt, rsp_ch.hit, rsp_ch.status);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	// response side: random back pressure plus two long hold-offs
	initial begin
		bit held_early;
		bit held_late;
		held_early = 1'b0;
		held_late = 1'b0;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if ((!held_early && sent_count >= 500) || (!held_late && sent_count >= 1300)) begin
				if (!held_early)
					held_early = 1'b1;
				else
					held_late = 1'b1;
				rsp_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else if (calm || $urandom_range(0, 3) != 0) begin
				rsp_ch.ready = 1'b1;
				@(negedge clk);
			end else begin
				rsp_ch.ready = 1'b0;
				repeat (pick_gap() + 1) @(negedge clk);
			end
		end
	end

	initial begin
		int seg;
		int k;
		int r;
		int r2;
		int p;
		cmd_t c;
		logic [ADDR_W-1:0] a;
		logic [COUNT_W-1:0] n;

		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_RETIRE;
		req_ch.address = '0;
		req_ch.count = '0;
		sb = new();
		foreach (addr_pool[i])
			addr_pool[i] = ADDR_W'($urandom);
		addr_pool[0] = '0;
		addr_pool[1] = '1;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: step counts, free run, empty table, duplicates, freed slots
		send_cmd(CMD_STEP, '0, 32'hFFFF_FFFF);
		send_cmd(CMD_RETIRE, 24'h000000, '0);
		send_cmd(CMD_STEP, '0, 32'h0);
		send_cmd(CMD_RETIRE, 24'h000000, '0);
		send_cmd(CMD_RUN, '0, '0);
		send_cmd(CMD_RETIRE, 24'hFFFFFF, '0);
		send_cmd(CMD_ADD, 24'h000000, '0);
		send_cmd(CMD_ADD, 24'hFFFFFF, '0);
		send_cmd(CMD_ADD, 24'h000000, '0);
		send_cmd(CMD_RETIRE, 24'h7FFFFF, '0);
		send_cmd(CMD_RETIRE, 24'hFFFFFF, '0);
		send_cmd(CMD_STEP, '0, 32'd2);
		send_cmd(CMD_RETIRE, 24'h000001, '0);
		send_cmd(CMD_RETIRE, 24'h000000, '0);
		send_cmd(CMD_RETIRE, 24'h000001, '0);
		send_cmd(CMD_DELETE, 24'h123456, '0);
		send_cmd(CMD_DELETE, 24'h000000, '0);
		send_cmd(CMD_ADD, 24'hABCDEF, '0);
		send_cmd(CMD_DELETE, 24'hABCDEF, '0);
		send_cmd(CMD_ADD, 24'hFFFFFF, '0);
		send_cmd(CMD_DELETE, 24'hFFFFFF, '0);
		send_cmd(CMD_DELETE, 24'hFFFFFF, '0);
		send_cmd(CMD_SPARE_FIRST, 24'hFFFFFF, 32'hFFFF_FFFF);
		send_cmd(CMD_SPARE_LAST, 24'h000000, 32'h0);

		for (seg = 0; seg < SEGMENTS; seg++) begin
			calm = (seg == 3 || seg == 8);
			p = seg % 3;
			for (k = 0; k < SEGMENT_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				if (r < prof_ret[p])
					c = CMD_RETIRE;
				else if (r < prof_ret[p] + prof_add[p])
					c = CMD_ADD;
				else if (r < prof_ret[p] + prof_add[p] + prof_del[p])
					c = CMD_DELETE;
				else if (r < prof_ret[p] + prof_add[p] + prof_del[p] + prof_step[p])
					c = CMD_STEP;
				else if (r < prof_ret[p] + prof_add[p] + prof_del[p] + prof_step[p] + prof_run[p])
					c = CMD_RUN;
				else
					c = cmd_t'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
				// a small address pool keeps hits, duplicates and a full table likely
				if ($urandom_range(0, 99) < 85)
					a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
				else
					a = ADDR_W'($urandom);
				r2 = $urandom_range(0, 99);
				if (r2 < 70)
					n = $urandom_range(0, 6);
				else if (r2 < 90)
					n = $urandom_range(0, 40);
				else
					n = $urandom;
				send_cmd(c, a, n);
			end
		end
		calm = 1'b0;
		req_ch.valid = 1'b0;

		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);

		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+design
design/bsdu_pkg.sv
design/bsdu_if.sv
design/breakpoint_step_debug_unit_top.sv
verif/breakpoint_step_debug_unit_top_test.sv
